>>> src/bd_pkg.sv
// Shared types for the bounded deque: request codes, status codes and the
// command word that the controller broadcasts to the row of storage cells.
// No dependencies.
package bd_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_PEEK_HEAD = 3'd2,
    OP_PEEK_TAIL = 3'd3,
    OP_POP_HEAD  = 3'd4,
    OP_POP_TAIL  = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_WR
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic signed [31:0] value;
  } cell_ctl_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned CAP_RESET = 256;

endpackage

>>> src/bd_cell.sv
// One storage cell of the deque row: holds the entry at a fixed position
// counted from the head and shifts with its neighbors. Depends on bd_pkg.
module bd_cell import bd_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned POS_W = 9
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [POS_W-1:0]     wr_pos,
  input  logic [POS_W-1:0]     tail_pos,
  input  logic [DATA_W-1:0]    left_i,
  input  logic [DATA_W-1:0]    right_i,
  output logic [DATA_W-1:0]    data_o,
  output logic [DATA_W-1:0]    leaf_o
);

  logic [DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CELL_SHR: data_r <= left_i;
      CELL_SHL: data_r <= right_i;
      CELL_WR: begin
        if (wr_pos == POS_W'(IDX)) begin
          data_r <= ctl.value;
        end
      end
      default: data_r <= data_r;
    endcase
  end

  assign data_o = data_r;
  // Only the tail cell contributes to the read-out tree.
  assign leaf_o = (tail_pos == POS_W'(IDX)) ? data_r : '0;

endmodule

>>> src/bd_tree.sv
// Registered binary OR tree that collects the single non-zero leaf of the
// cell row; every level of the tree is registered. Depends on bd_pkg.
module bd_tree import bd_pkg::*; #(
  parameter int unsigned N = 256
) (
  input  logic              clk,
  input  logic [DATA_W-1:0] leaf_i [N],
  output logic [DATA_W-1:0] root_o
);

  localparam int unsigned LVL = $clog2(N);
  localparam int unsigned P   = 1 << LVL;

  logic [DATA_W-1:0] leaf_w [P];
  logic [DATA_W-1:0] node_r [1:P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign leaf_w[i] = leaf_i[i];
    end else begin : g_pad
      assign leaf_w[i] = '0;
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_node
    if (2 * k >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        node_r[k] <= leaf_w[2*k-P] | leaf_w[2*k+1-P];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_r[k] <= node_r[2*k] | node_r[2*k+1];
      end
    end
  end

  assign root_o = node_r[1];

endmodule

>>> src/bounded_deque_top.sv
// Top level of the bounded deque: APB capacity register, request sequencer,
// cell row and tail read-out tree. Depends on bd_pkg, bd_cell and bd_tree.
//
// The deque is a row of DEPTH cells, cell 0 holding the head; a push at the
// head or a pop at the head shifts the whole row by one cell.
// Push, pop, peek head and clear finish in the cycle they are taken while the
// result register is free and no trim is due. Peek tail on a non-empty queue
// passes through S_EXEC and then waits in S_TREE while the registered OR tree
// settles; on an empty queue it is answered from S_EXEC. After the capacity
// register is lowered below the current count, the next request first drops
// one head entry per cycle before it is carried out. A new request is taken
// while a finished result still waits at the output.
module bounded_deque_top import bd_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_data,
  output logic [8:0]          out_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned POS_W    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int unsigned TREE_LAT = $clog2(DEPTH);
  localparam int unsigned TC_W     = $clog2(TREE_LAT + 1);
  localparam logic [CNT_W-1:0] DEPTH_CAP =
    (DEPTH > 511) ? CNT_W'(511) : CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_TREE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TC_W-1:0]   tcnt_r, tcnt_nxt;
  op_t               req_op_r;
  logic [DATA_W-1:0] req_val_r;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CNT_W-1:0]  out_count_r;

  logic [CNT_W-1:0]  eff_cap;
  logic              trim_need, out_free, accept, do_exec;
  op_t               cur_op;
  logic [DATA_W-1:0] cur_val;
  cell_ctl_t         ctl;
  cell_cmd_t         exec_cmd;
  status_t           exec_status;
  logic [DATA_W-1:0] exec_data;
  logic [CNT_W-1:0]  exec_count;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_leaf [DEPTH];
  logic [DATA_W-1:0] tail_data;
  logic [POS_W-1:0]  wr_pos, tail_pos;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    eff_cap = cap_r;
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_r > DEPTH_CAP) begin
      eff_cap = DEPTH_CAP;
    end
  end

  assign trim_need = (count_r > eff_cap);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;

  assign cur_op  = (state_r == S_IDLE) ? op_t'(in_req_type) : req_op_r;
  assign cur_val = (state_r == S_IDLE) ? in_value : req_val_r;

  // Outcome of the request once the count fits the capacity.
  always_comb begin
    exec_cmd    = CELL_HOLD;
    exec_status = ST_OK;
    exec_data   = '0;
    exec_count  = count_r;
    case (cur_op)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (count_r >= eff_cap) begin
          exec_status = ST_FULL;
        end else begin
          exec_cmd   = (cur_op == OP_PUSH_HEAD) ? CELL_SHR : CELL_WR;
          exec_count = count_r + CNT_W'(1);
        end
      end
      OP_PEEK_HEAD, OP_PEEK_TAIL, OP_POP_HEAD, OP_POP_TAIL, OP_CLEAR: begin
        if (count_r == '0) begin
          exec_status = ST_EMPTY;
        end else begin
          case (cur_op)
            OP_PEEK_HEAD: exec_data = cell_data[0];
            OP_PEEK_TAIL: exec_data = tail_data;
            OP_POP_HEAD: begin
              exec_cmd   = CELL_SHL;
              exec_count = count_r - CNT_W'(1);
            end
            OP_POP_TAIL:  exec_count = count_r - CNT_W'(1);
            default:      exec_count = '0;
          endcase
        end
      end
      default: exec_status = ST_OK;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    tcnt_nxt  = tcnt_r;
    count_nxt = count_r;
    do_exec   = 1'b0;
    ctl.cmd   = CELL_HOLD;
    ctl.value = cur_val;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // Simple requests finish in the cycle they are taken.
          if (!trim_need && (cur_op != OP_PEEK_TAIL) && out_free) begin
            do_exec = 1'b1;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (trim_need) begin
          ctl.cmd   = CELL_SHL;
          count_nxt = count_r - CNT_W'(1);
        end else if ((cur_op == OP_PEEK_TAIL) && (count_r != '0)) begin
          // The row is now stable; the tree has one level done at this edge.
          state_nxt = S_TREE;
          tcnt_nxt  = TC_W'(TREE_LAT - 1);
        end else if (out_free) begin
          do_exec   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TREE: begin
        if (tcnt_r != '0) begin
          tcnt_nxt = tcnt_r - TC_W'(1);
        end else if (out_free) begin
          do_exec   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (do_exec) begin
      ctl.cmd   = exec_cmd;
      count_nxt = exec_count;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tcnt_r      <= tcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r  <= op_t'(in_req_type);
      req_val_r <= in_value;
    end
    if (do_exec) begin
      out_status_r <= exec_status;
      out_data_r   <= exec_data;
      out_count_r  <= exec_count;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;

  // Cell row.
  assign wr_pos   = POS_W'(count_r);
  assign tail_pos = POS_W'(count_r - CNT_W'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = ctl.value;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    bd_cell #(
      .IDX   (i),
      .POS_W (POS_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_pos   (wr_pos),
      .tail_pos (tail_pos),
      .left_i   (left_w),
      .right_i  (right_w),
      .data_o   (cell_data[i]),
      .leaf_o   (cell_leaf[i])
    );
  end

  bd_tree #(
    .N (DEPTH)
  ) u_tree (
    .clk    (clk),
    .leaf_i (cell_leaf),
    .root_o (tail_data)
  );

endmodule

>>> src/bd_checker.sv
// Port-level checks for the bounded deque result channel, bound to the
// top level. Depends on bd_pkg and bounded_deque_top.
module bd_port_checks import bd_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_data,
  input logic [8:0]  out_count
);

  // A refused push never carries data.
  a_full_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_data == '0))
    else $error("full status with non-zero data");

  // An empty status only comes from an empty queue and leaves it empty.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> ((out_count == '0) && (out_data == '0)))
    else $error("empty status with entries or data");

  // The count never goes past the storage depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= DEPTH))
    else $error("count exceeds depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_data) && $stable(out_count)))
    else $error("stalled result changed");

endmodule

bind bounded_deque_top bd_port_checks #(
  .DEPTH (DEPTH)
) u_bd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_data   (out_data),
  .out_count  (out_count)
);

>>> tb/sv/bd_checker.sv
// Checker for the bounded deque: watches the request, result and APB ports,
// predicts every result and compares it field by field.
// Depends on bd_pkg for the request and status codes.
`timescale 1ns / 100ps
module bd_checker import bd_pkg::*; #(
  parameter int unsigned DEPTH    = 256,
  parameter logic [2:0]  CAP_ADDR = 3'd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic signed [31:0] out_data,
  input  logic [8:0]         out_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  typedef struct {
    status_t            status;
    logic signed [31:0] data;
    logic [CNT_W-1:0]   count;
  } bd_result_t;

  logic signed [31:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]   head_ptr;
  int unsigned        live_cnt;
  logic [8:0]         cap_reg;
  bd_result_t         answer_q [$];

  function automatic logic [PTR_W-1:0] ring_slot(int unsigned ofs);
    return PTR_W'(head_ptr + ofs);
  endfunction

  // Updates the deque copy for one request and returns the result it owes.
  function automatic bd_result_t deque_apply(logic [2:0] op, logic signed [31:0] val);
    bd_result_t  r;
    int unsigned lim;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
    r.status = ST_OK;
    r.data   = '0;
    // A lowered capacity first costs the oldest entries at the head.
    if (live_cnt > lim) begin
      head_ptr = ring_slot(live_cnt - lim);
      live_cnt = lim;
    end
    case (op)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (live_cnt >= lim) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_HEAD) begin
          head_ptr = ring_slot(DEPTH - 1);
          ring_mem[head_ptr] = val;
          live_cnt++;
        end else begin
          ring_mem[ring_slot(live_cnt)] = val;
          live_cnt++;
        end
      end
      OP_PEEK_HEAD, OP_PEEK_TAIL, OP_POP_HEAD, OP_POP_TAIL, OP_CLEAR: begin
        if (live_cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_PEEK_HEAD) begin
          r.data = ring_mem[ring_slot(0)];
        end else if (op == OP_PEEK_TAIL) begin
          r.data = ring_mem[ring_slot(live_cnt - 1)];
        end else if (op == OP_POP_HEAD) begin
          head_ptr = ring_slot(1);
          live_cnt--;
        end else if (op == OP_POP_TAIL) begin
          live_cnt--;
        end else begin
          live_cnt = 0;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(live_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    bd_result_t want;
    if (!rst_n) begin
      head_ptr = '0;
      live_cnt = 0;
      cap_reg  = 9'(CAP_RESET);
      answer_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        cap_reg = pwdata[8:0];
      end
      // Results are matched before new requests: none can answer a request
      // taken at the same edge.
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("result with no request outstanding: status %0d data %0d count %0d",
                 out_status, out_data, out_count);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, out_data);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        answer_q.push_back(deque_apply(in_req_type, in_value));
      end
      pending <= answer_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the bounded deque: clock, reset, request and APB stimulus,
// result-side back-pressure and the verdict.
// Depends on bd_pkg, bounded_deque_top and bd_checker.
`timescale 1ns / 100ps
module tb import bd_pkg::*; ();

  localparam int unsigned DEPTH           = 256;
  localparam logic [2:0]  CAP_ADDR        = 3'd0;
  localparam logic [2:0]  OP_NOP          = 3'd7;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [2:0]         in_req_type = OP_PUSH_HEAD;
  logic signed [31:0] in_value    = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_data;
  logic [8:0]         out_count;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = CAP_ADDR;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                 fail_count;
  int                 pending;
  int unsigned        send_idle_pct = 20;
  int unsigned        recv_idle_pct = 48;
  int unsigned        hold_off_asks = 0;

  bounded_deque_top #(.DEPTH(DEPTH)) i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_value,
    .out_valid, .out_ready, .out_status, .out_data, .out_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bd_checker #(.DEPTH(DEPTH), .CAP_ADDR(CAP_ADDR)) i_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_value,
    .out_valid, .out_ready, .out_status, .out_data, .out_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off per ask.
  initial begin : result_sink
    int unsigned stalls_done;
    stalls_done = 0;
    forever begin
      @(posedge clk);
      if (hold_off_asks != stalls_done) begin
        stalls_done++;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [2:0] pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
    r = $urandom_range(99);
    if (r < 3) return OP_CLEAR;
    if (r < 8) return OP_NOP;
    return 3'($urandom_range(OP_POP_TAIL, OP_PEEK_HEAD));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Presents one request and returns at the edge that takes it.
  task automatic offer(logic [2:0] op, logic signed [31:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [8:0] cap);
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= 32'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_mix(int unsigned n, int unsigned push_pct);
    repeat (n) offer(pick_op(push_pct), pick_value());
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every operation on an empty deque, then the value extremes.
    offer(OP_PEEK_HEAD, pick_value());
    offer(OP_PEEK_TAIL, pick_value());
    offer(OP_POP_HEAD, pick_value());
    offer(OP_POP_TAIL, pick_value());
    offer(OP_CLEAR, pick_value());
    offer(OP_NOP, 32'sh5A5A5A5A);
    offer(OP_PUSH_HEAD, 32'sh7FFFFFFF);
    offer(OP_PUSH_TAIL, 32'sh80000000);
    offer(OP_PUSH_HEAD, -32'sd1);
    offer(OP_PUSH_TAIL, '0);
    offer(OP_PEEK_HEAD, pick_value());
    offer(OP_PEEK_TAIL, pick_value());
    offer(OP_NOP, -32'sd1);
    offer(OP_POP_HEAD, pick_value());
    offer(OP_POP_TAIL, pick_value());
    offer(OP_PEEK_HEAD, pick_value());
    offer(OP_PEEK_TAIL, pick_value());
    offer(OP_CLEAR, pick_value());
    offer(OP_PEEK_HEAD, pick_value());

    set_capacity(9'd1);
    run_mix(60, 50);
    // A zero capacity behaves as one.
    set_capacity(9'd0);
    run_mix(40, 50);

    // Fill to the top while the result side holds off for a long stretch.
    set_capacity(9'd256);
    hold_off_asks <= hold_off_asks + 1;
    run_mix(270, 100);

    quiesce();
    send_idle_pct <= 48;
    recv_idle_pct <= 20;
    // Dropping from full to one trims almost every entry in the next request.
    set_capacity(9'd1);
    run_mix(30, 50);
    set_capacity(9'd511);
    run_mix(150, 75);
    set_capacity(9'd100);
    run_mix(150, 55);

    quiesce();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    set_capacity(9'd2);
    run_mix(60, 50);
    set_capacity(9'd300);
    run_mix(200, 70);
    repeat (3) begin
      set_capacity(9'($urandom_range(256, 1)));
      run_mix(90, 55);
    end

    quiesce();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
